FILE: hdl/ndf_pkg.sv
// ----------------------------------------------------------------------------
// ndf_pkg: shared definitions of the 3x3 neighbor density filter
// Register indexes, reset values, size limits and the result word layout.
// ----------------------------------------------------------------------------
package ndf_pkg;

  localparam int NDF_MAX_WIDTH  = 1024;
  localparam int NDF_MAX_HEIGHT = 1024;

  localparam int NDF_CFG_DW = 11;
  localparam int NDF_CFG_AW = 2;

  localparam int NDF_RST_WIDTH       = 640;
  localparam int NDF_RST_HEIGHT      = 480;
  localparam logic [3:0] NDF_RST_MIN_DENSITY = 4'd5;
  localparam logic [7:0] NDF_RST_FG_VALUE    = 8'd255;

  // Depth of the result queue in front of the output port.
  localparam int NDF_OUT_DEPTH = 3;

  typedef enum logic [NDF_CFG_AW-1:0] {
    CFG_WIDTH       = 2'd0,
    CFG_HEIGHT      = 2'd1,
    CFG_MIN_DENSITY = 2'd2,
    CFG_FG_VALUE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       frame_done;
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic [7:0] out_value;
  } result_t;

endpackage

FILE: hdl/ndf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ndf_cfg_regs: configuration registers
// Holds the clamped last column and row indexes, the density threshold and
// the foreground value.
// ----------------------------------------------------------------------------
module ndf_cfg_regs #(
  parameter int MAX_WIDTH  = ndf_pkg::NDF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ndf_pkg::NDF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ndf_pkg::NDF_CFG_AW-1:0] cfg_idx_i,
  input  logic [ndf_pkg::NDF_CFG_DW-1:0] cfg_data_i,
  output logic [CW-1:0]                 col_last_o,
  output logic [RW-1:0]                 row_last_o,
  output logic [3:0]                    min_density_o,
  output logic [7:0]                    fg_value_o
);

  localparam int DW  = ndf_pkg::NDF_CFG_DW;
  localparam int KWC = (CW + 1 > DW) ? CW + 1 : DW;
  localparam int KWR = (RW + 1 > DW) ? RW + 1 : DW;
  localparam int RstColLast =
    ((ndf_pkg::NDF_RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : ndf_pkg::NDF_RST_WIDTH) - 1;
  localparam int RstRowLast =
    ((ndf_pkg::NDF_RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : ndf_pkg::NDF_RST_HEIGHT) - 1;

  logic [CW-1:0]  col_last_q, col_last_d;
  logic [RW-1:0]  row_last_q, row_last_d;
  logic [3:0]     min_density_q;
  logic [7:0]     fg_value_q;
  logic [KWC-1:0] wide_w;
  logic [KWR-1:0] wide_h;
  logic [KWC-1:0] wm1;
  logic [KWR-1:0] hm1;

  // A size below 3 acts as 3 and one above the maximum acts as the maximum.
  always_comb begin
    wide_w = KWC'(cfg_data_i);
    wide_h = KWR'(cfg_data_i);
    wm1    = wide_w - KWC'(1);
    hm1    = wide_h - KWR'(1);
    if (wide_w < KWC'(3)) begin
      col_last_d = CW'(2);
    end else if (wide_w > KWC'(MAX_WIDTH)) begin
      col_last_d = CW'(MAX_WIDTH - 1);
    end else begin
      col_last_d = wm1[CW-1:0];
    end
    if (wide_h < KWR'(3)) begin
      row_last_d = RW'(2);
    end else if (wide_h > KWR'(MAX_HEIGHT)) begin
      row_last_d = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last_d = hm1[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q    <= CW'(RstColLast);
      row_last_q    <= RW'(RstRowLast);
      min_density_q <= ndf_pkg::NDF_RST_MIN_DENSITY;
      fg_value_q    <= ndf_pkg::NDF_RST_FG_VALUE;
    end else if (cfg_we_i) begin
      unique case (ndf_pkg::cfg_idx_e'(cfg_idx_i))
        ndf_pkg::CFG_WIDTH:       col_last_q    <= col_last_d;
        ndf_pkg::CFG_HEIGHT:      row_last_q    <= row_last_d;
        ndf_pkg::CFG_MIN_DENSITY: min_density_q <= cfg_data_i[3:0];
        ndf_pkg::CFG_FG_VALUE:    fg_value_q    <= cfg_data_i[7:0];
      endcase
    end
  end

  assign col_last_o    = col_last_q;
  assign row_last_o    = row_last_q;
  assign min_density_o = min_density_q;
  assign fg_value_o    = fg_value_q;

endmodule

FILE: hdl/ndf_line_store.sv
// ----------------------------------------------------------------------------
// ndf_line_store: line store of foreground marks
// One synchronous memory, two marks per column: bit 1 is the row two lines
// up, bit 0 the row one line up. A write to the address being read in the
// same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module ndf_line_store #(
  parameter int MAX_WIDTH = ndf_pkg::NDF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [CW-1:0] rd_addr_i,
  output logic [1:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [CW-1:0] wr_addr_i,
  input  logic [1:0]    wr_data_i
);

  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/ndf_out_fifo.sv
// ----------------------------------------------------------------------------
// ndf_out_fifo: result queue
// Small register queue that decouples the filter pipeline from the output
// handshake.
// ----------------------------------------------------------------------------
module ndf_out_fifo #(
  localparam int DEPTH = ndf_pkg::NDF_OUT_DEPTH,
  localparam int PW    = $clog2(DEPTH),
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ndf_pkg::result_t push_data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ndf_pkg::result_t data_o,
  output logic [NW-1:0]    count_o
);

  ndf_pkg::result_t entries_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;
  logic          pop;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + NW'(1);
        2'b01:   count_q <= count_q - NW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: hdl/neighbor_density_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// neighbor_density_filter_3x3_unit: 3x3 neighbor density filter
// Cleans a binary foreground mask streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one mask pixel per word in tdata, with tuser set
//   on the first pixel of a frame. Each pixel becomes a mark (pixel equals
//   fg_value). For every interior pixel, once its lower-right neighbor has
//   arrived, one word leaves on the master stream with the value (fg_value
//   if the center is marked and at least min_density neighbors are, else 0),
//   its row and column; tlast is set on the last interior pixel of a frame.
//   Border pixels give no output word.
//   Throughput is one pixel per clock while tready is high. Each pixel is
//   registered with its line store read; from these the window is updated
//   and the result is decided and queued. The line store memory is read at
//   the column of each arriving pixel and written back in the following cycle.
//   When the receiver stalls, results collect in a three-word queue and the
//   slave side drops tready once the queue and the pipeline stage fill it.
//   Reset clears the position counters, the window and the queue and loads
//   640x480, min_density 5, fg_value 255; the line store is not cleared.
//   Configuration writes go through cfg_we_i, cfg_idx_i and cfg_data_i.
// ----------------------------------------------------------------------------
module neighbor_density_filter_3x3_unit #(
  parameter int MAX_WIDTH  = ndf_pkg::NDF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ndf_pkg::NDF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ndf_pkg::NDF_CFG_AW-1:0] cfg_idx_i,
  input  logic [ndf_pkg::NDF_CFG_DW-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel
  input  logic                           s_axis_tuser,  // [0] frame_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_value, [17:8] out_row, [27:18] out_col, [31:28] zero
  output logic [31:0]                    m_axis_tdata,
  output logic                           m_axis_tlast   // frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int NW = $clog2(ndf_pkg::NDF_OUT_DEPTH + 1);

  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic [3:0]    min_density;
  logic [7:0]    fg_value;

  logic          accept;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          mark;

  logic          p1_valid_q;
  logic [CW-1:0] p1_col_q;
  logic [RW-1:0] p1_row_q;
  logic          p1_mark_q;

  logic [1:0]    line_rdata;
  logic [8:0]    window_q, window_d;
  logic [3:0]    ncount;
  logic          res_push;
  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;
  ndf_pkg::result_t res;
  ndf_pkg::result_t out_word;
  logic [NW-1:0] fifo_count;

  ndf_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .col_last_o   (col_last),
    .row_last_o   (row_last),
    .min_density_o(min_density),
    .fg_value_o   (fg_value)
  );

  // Input stage: position of the arriving pixel and its mark.
  // The pipeline stage counts as occupied so that its result always finds room.
  assign s_axis_tready = ((NW + 1)'(fifo_count) + (NW + 1)'(p1_valid_q))
                         < (NW + 1)'(ndf_pkg::NDF_OUT_DEPTH);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign col_cur = s_axis_tuser ? '0 : col_q;
  assign row_cur = s_axis_tuser ? '0 : row_q;
  assign mark    = (s_axis_tdata == fg_value);

  always_comb begin
    if (col_cur >= col_last) begin
      col_d = '0;
      row_d = (row_cur >= row_last) ? '0 : row_cur + RW'(1);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_col_q  <= col_cur;
      p1_row_q  <= row_cur;
      p1_mark_q <= mark;
    end
  end

  ndf_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_lines (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(col_cur),
    .rd_data_o(line_rdata),
    .wr_en_i  (p1_valid_q),
    .wr_addr_i(p1_col_q),
    .wr_data_i({line_rdata[0], p1_mark_q})
  );

  // Window stage: bit 3*row+col, column 2 holds the newest marks.
  always_comb begin
    window_d = {p1_mark_q, window_q[8:7],
                line_rdata[0], window_q[5:4],
                line_rdata[1], window_q[2:1]};
    ncount = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        ncount = ncount + 4'(window_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (p1_valid_q) begin
      window_q <= window_d;
    end
  end

  assign res_push = p1_valid_q && (p1_row_q >= RW'(2)) && (p1_col_q >= CW'(2));
  assign col_m1   = p1_col_q - CW'(1);
  assign row_m1   = p1_row_q - RW'(1);

  always_comb begin
    res.out_value  = (window_d[4] && (ncount >= min_density)) ? fg_value : 8'd0;
    res.out_row    = 10'(row_m1);
    res.out_col    = 10'(col_m1);
    res.frame_done = (p1_row_q >= row_last) && (p1_col_q >= col_last);
  end

  ndf_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .push_data_i(res),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (out_word),
    .count_o    (fifo_count)
  );

  assign m_axis_tdata = {4'd0, out_word.out_col, out_word.out_row, out_word.out_value};
  assign m_axis_tlast = out_word.frame_done;

endmodule

FILE: tb/tb_neighbor_density_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// tb_neighbor_density_filter_3x3_unit: self-checking bench of the density filter
// Streams binary masks through the filter and predicts every output word with
// its own copy of the line stores, the 3x3 mark window and the position
// counters. Covers the small-size clamp, random and extreme density thresholds,
// foreground values at the extremes, frames without a start flag, cut-short
// frames and noise, with random idling and backpressure on both streams.
// ----------------------------------------------------------------------------
module tb_neighbor_density_filter_3x3_unit;
  import ndf_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PIXELS  = 600;
  localparam int NO_IDLE_PIXELS = 150;
  localparam int REPORT_LIMIT   = 10;

  // Predicts the output words of the filter and checks them in order.
  class density_scoreboard;
    bit          upper_marks[NDF_MAX_WIDTH];
    bit          middle_marks[NDF_MAX_WIDTH];
    bit [8:0]    window;
    int unsigned col_pos;
    int unsigned row_pos;
    bit [10:0]   width_reg;
    bit [10:0]   height_reg;
    bit [3:0]    min_density;
    bit [7:0]    fg_value;
    result_t     expected_words[$];
    int unsigned errors;
    int unsigned words_checked;
    int unsigned kept_count;
    int unsigned frame_ends;

    function new();
      width_reg   = 11'(NDF_RST_WIDTH);
      height_reg  = 11'(NDF_RST_HEIGHT);
      min_density = NDF_RST_MIN_DENSITY;
      fg_value    = NDF_RST_FG_VALUE;
    endfunction

    function int unsigned clamp_size(bit [10:0] raw, int unsigned hi);
      if (raw < 3) return 3;
      if (raw > hi) return hi;
      return raw;
    endfunction

    function void load_reg(cfg_idx_e idx, bit [10:0] value);
      case (idx)
        CFG_WIDTH:       width_reg   = value;
        CFG_HEIGHT:      height_reg  = value;
        CFG_MIN_DENSITY: min_density = value[3:0];
        CFG_FG_VALUE:    fg_value    = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(bit [7:0] pixel, bit frame_start);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned nbrs;
      bit          mark;
      bit [2:0]    fresh;
      bit [2:0]    bits;
      result_t     word;
      w = clamp_size(width_reg, NDF_MAX_WIDTH);
      h = clamp_size(height_reg, NDF_MAX_HEIGHT);
      mark = (pixel == fg_value);
      if (frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      // Newest column enters at bit 2 of each window row.
      fresh = {mark, middle_marks[c], upper_marks[c]};
      for (int k = 0; k < 3; k++) begin
        bits = window[3*k +: 3];
        window[3*k +: 3] = {fresh[k], bits[2:1]};
      end
      upper_marks[c]  = middle_marks[c];
      middle_marks[c] = mark;
      if (r >= 2 && c >= 2) begin
        nbrs = $countones(window) - window[4];
        word.out_value  = (window[4] && nbrs >= min_density) ? fg_value : 8'd0;
        word.out_row    = 10'(r - 1);
        word.out_col    = 10'(c - 1);
        word.frame_done = (r >= h - 1 && c >= w - 1);
        if (window[4] && nbrs >= min_density) kept_count++;
        if (word.frame_done) frame_ends++;
        expected_words.push_back(word);
      end
      if (c >= w - 1) begin
        col_pos = 0;
        row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word value=%0d row=%0d col=%0d last=%b",
                         got.out_value, got.out_row, got.out_col, got.frame_done));
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.out_value !== want.out_value || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.frame_done !== want.frame_done) begin
        report({$sformatf("word %0d: expected value=%0d row=%0d col=%0d last=%b",
                          words_checked, want.out_value, want.out_row, want.out_col,
                          want.frame_done),
                $sformatf(", got value=%0d row=%0d col=%0d last=%b",
                          got.out_value, got.out_row, got.out_col, got.frame_done)});
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction

    function void close_out();
      if (expected_words.size() != 0)
        report($sformatf("%0d expected words never arrived", expected_words.size()));
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [NDF_CFG_AW-1:0] cfg_idx_i     = '0;
  logic [NDF_CFG_DW-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  density_scoreboard sb = new();

  bit          no_idle   = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned pixels_sent  = 0;
  int unsigned settings     = 0;

  neighbor_density_filter_3x3_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: counts down a hold-off, else always ready (no_idle) or random idling.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else if (no_idle) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_value  = m_axis_tdata[7:0];
      got.out_row    = m_axis_tdata[17:8];
      got.out_col    = m_axis_tdata[27:18];
      got.frame_done = m_axis_tlast;
      sb.check_word(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(input logic [7:0] pixel, input logic frame_start);
    while (!no_idle && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 8'($urandom);
      s_axis_tuser  = 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pixel;
    s_axis_tuser  = frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(pixel, frame_start);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] mask_pixel(input int fg_pct);
    if ($urandom_range(0, 99) < fg_pct) return sb.fg_value;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input int unsigned n_pix, input int fg_pct,
                            input bit with_start);
    for (int unsigned i = 0; i < n_pix; i++)
      send_pixel(mask_pixel(fg_pct), with_start && i == 0);
  endtask

  task automatic send_pattern(input logic [8:0] marks, input logic [7:0] other);
    for (int i = 0; i < 9; i++)
      send_pixel(marks[i] ? sb.fg_value : other, i == 0);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [10:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    sb.load_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Registers change only once the pipeline has emptied.
  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    settings++;
  endtask

  initial begin
    int unsigned random_base;
    int unsigned frame_pix;
    int unsigned n_frames;
    int unsigned kind;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned dens;
    int          pct;
    bit          held;
    logic [7:0]  fg;
    held = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Smallest frame through the lower size clamp: one interior pixel each.
    set_reg(CFG_WIDTH, 11'd0);
    set_reg(CFG_HEIGHT, 11'd2);
    set_reg(CFG_MIN_DENSITY, 11'd8);
    set_reg(CFG_FG_VALUE, 11'd255);
    send_pattern(9'h1FF, 8'd0);
    wait_drain();
    set_reg(CFG_MIN_DENSITY, 11'd0);
    send_pattern(9'h010, 8'd0);
    wait_drain();
    // Thresholds above eight can never be met.
    set_reg(CFG_MIN_DENSITY, 11'd15);
    send_pattern(9'h1FF, 8'd0);
    wait_drain();

    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_PIXELS) begin
      wait_drain();
      // The first part of the random run goes without random idling.
      no_idle = (pixels_sent - random_base < NO_IDLE_PIXELS);
      w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      dens  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      case ($urandom_range(0, 3))
        0:       fg = 8'd0;
        1:       fg = 8'd255;
        default: fg = 8'($urandom);
      endcase
      n_frames = $urandom_range(1, 3);
      if (!held) begin
        // Long receiver hold-off while frames keep coming: the block must stall.
        w_raw    = 12;
        h_raw    = 6;
        n_frames = 3;
        hold_req = 1'b1;
        held     = 1'b1;
      end
      set_reg(CFG_WIDTH, 11'(w_raw));
      set_reg(CFG_HEIGHT, 11'(h_raw));
      set_reg(CFG_MIN_DENSITY, 11'($urandom & 32'h7F0) | 11'(dens));
      set_reg(CFG_FG_VALUE, 11'($urandom & 32'h700) | 11'(fg));
      frame_pix = sb.clamp_size(11'(w_raw), NDF_MAX_WIDTH) *
                  sb.clamp_size(11'(h_raw), NDF_MAX_HEIGHT);
      for (int f = 0; f < n_frames; f++) begin
        kind = $urandom_range(0, 9);
        pct  = $urandom_range(40, 95);
        if (kind == 1 && f != 0) begin
          repeat ($urandom_range(5, 20))
            send_pixel(8'($urandom), $urandom_range(0, 9) == 0);
        end else if (kind == 0) begin
          send_frame($urandom_range(1, frame_pix - 1), pct, 1'b1);
        end else begin
          // Later frames often rely on the counters wrapping by themselves.
          send_frame(frame_pix, pct, f == 0 || $urandom_range(0, 3) != 0);
        end
      end
    end

    wait_drain();
    sb.close_out();
    $display("Run covered %0d pixels over %0d settings, small sizes clamped to 3,",
             pixels_sent, settings);
    $display("and %0d checked words (%0d kept, %0d frame ends).",
             sb.words_checked, sb.kept_count, sb.frame_ends);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
